// ----- hdl/fpcar_pkg.sv -----
`timescale 1ns / 1ps

package fpcar_pkg;

	// Memory and line geometry
	localparam int NUM_COMB      = 4;
	localparam int NUM_ALLPASS   = 4;
	localparam int LINE_IW       = 2;
	localparam int COMB_PW       = 11;
	localparam int AP_PW         = 10;
	localparam int COMB_AW       = LINE_IW + COMB_PW;
	localparam int AP_AW         = LINE_IW + AP_PW;
	localparam int COMB_DEPTH    = 1 << COMB_PW;
	localparam int AP_DEPTH      = 1 << AP_PW;
	localparam int COMB_MEM_SIZE = 1 << COMB_AW;
	localparam int AP_MEM_SIZE   = 1 << AP_AW;
	localparam int COMB_LW       = 12;
	localparam int AP_LW         = 11;

	// Q15 coefficients
	localparam logic signed [16:0] DAMP1_Q15    = 17'sd6554;
	localparam logic signed [16:0] DAMP2_Q15    = 17'sd26214;
	localparam logic signed [16:0] FEEDBACK_Q15 = 17'sd27525;

	// Configuration register indexes
	localparam logic [3:0] REG_COMB_A = 4'd0;
	localparam logic [3:0] REG_COMB_B = 4'd1;
	localparam logic [3:0] REG_COMB_C = 4'd2;
	localparam logic [3:0] REG_COMB_D = 4'd3;
	localparam logic [3:0] REG_AP_A   = 4'd4;
	localparam logic [3:0] REG_AP_B   = 4'd5;
	localparam logic [3:0] REG_AP_C   = 4'd6;
	localparam logic [3:0] REG_AP_D   = 4'd7;

	// Reset lengths
	localparam logic [COMB_LW-1:0] COMB_LEN_A_RST = 12'd1116;
	localparam logic [COMB_LW-1:0] COMB_LEN_B_RST = 12'd1188;
	localparam logic [COMB_LW-1:0] COMB_LEN_C_RST = 12'd1277;
	localparam logic [COMB_LW-1:0] COMB_LEN_D_RST = 12'd1356;
	localparam logic [AP_LW-1:0]   AP_LEN_A_RST   = 11'd556;
	localparam logic [AP_LW-1:0]   AP_LEN_B_RST   = 11'd441;
	localparam logic [AP_LW-1:0]   AP_LEN_C_RST   = 11'd341;
	localparam logic [AP_LW-1:0]   AP_LEN_D_RST   = 11'd225;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_C_RD,
		ST_C_MUL,
		ST_C_DAMP,
		ST_C_WR,
		ST_A_RD,
		ST_A_WR,
		ST_DONE
	} state_t;

	// Saturate a wide signed value to 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
		logic signed [15:0] r;
		if (v > 22'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -22'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// ----- hdl/fixed_point_comb_allpass_reverb.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake                Payload
// s_*       in   s_tvalid / s_tready      s_tdata[15:0] sample_in
// m_*       out  m_tvalid / m_tready      m_tdata[11:0] sample_out, [15:12] zero
// cfg_*     in   cfg_valid / cfg_ready    cfg_index register, cfg_data value
//
// A sample is taken only in the idle state, so a new one waits until the last is
// through. Each comb line steps through read, damping multiply, damping sum, and
// feedback multiply and write; each allpass stage through read and write; then a
// hand-over state. All share one port pair on each of the two delay memories.
// After reset a clearing pass zeroes every address of both memories; no sample is
// accepted during it. A result waiting in the output register does not stop the
// next sample from being accepted; only the hand-over of a new result waits.

module fixed_point_comb_allpass_reverb
	import fpcar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [11:0] sample_out, [15:12] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	state_t state_q, state_d;

	logic [LINE_IW-1:0] line_q;
	logic [COMB_AW-1:0] clr_q;
	logic [COMB_LW-1:0] comb_len_q [NUM_COMB];
	logic [AP_LW-1:0]   ap_len_q [NUM_ALLPASS];
	logic [COMB_PW-1:0] comb_pos_q [NUM_COMB];
	logic [AP_PW-1:0]   ap_pos_q [NUM_ALLPASS];
	logic signed [15:0] lp_q [NUM_COMB];
	logic signed [15:0] in_q;
	logic signed [17:0] sum_q;
	logic signed [20:0] acc_q;
	logic signed [32:0] prod_s2;
	logic               m_tvalid_q;
	logic [11:0]        m_data_q;

	logic [15:0] comb_mem [COMB_MEM_SIZE];
	logic [15:0] ap_mem [AP_MEM_SIZE];
	logic [15:0] comb_rd_q, ap_rd_q;

	logic [COMB_AW-1:0] comb_addr, comb_waddr;
	logic [AP_AW-1:0]   ap_addr, ap_waddr;
	logic               comb_we, ap_we;
	logic [15:0]        comb_wdata, ap_wdata;

	logic signed [32:0] damp_sum;
	logic signed [33:0] fb_prod;
	logic signed [21:0] comb_v;
	logic signed [15:0] comb_sat;
	logic signed [20:0] ap_buf, ap_y;
	logic signed [21:0] ap_v;
	logic signed [15:0] ap_sat;
	logic [COMB_LW-1:0] comb_eff, comb_next;
	logic [AP_LW-1:0]   ap_eff, ap_next;
	logic [11:0]        clamp_out;
	logic               in_acc, out_free;

	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {4'd0, m_data_q};

	// Memory addresses follow the current line and its position
	assign comb_addr = {line_q, comb_pos_q[line_q]};
	assign ap_addr   = {line_q, ap_pos_q[line_q]};

	// Damping lowpass, feedback and comb write value
	always_comb begin
		damp_sum = prod_s2 + 33'(lp_q[line_q]) * 33'(DAMP1_Q15);
		fb_prod  = 34'(lp_q[line_q]) * 34'(FEEDBACK_Q15);
		comb_v   = 22'(in_q) + 22'(fb_prod >>> 15);
		comb_sat = sat16(comb_v);
	end

	// Allpass stage of gain one half
	always_comb begin
		ap_buf = 21'($signed(ap_rd_q));
		ap_y   = ap_buf - acc_q;
		ap_v   = 22'(acc_q) + 22'(ap_buf >>> 1);
		ap_sat = sat16(ap_v);
	end

	// Effective lengths and wrapped next positions
	always_comb begin
		if (comb_len_q[line_q] == '0) begin
			comb_eff = COMB_LW'(1);
		end else if (comb_len_q[line_q] > COMB_LW'(COMB_DEPTH)) begin
			comb_eff = COMB_LW'(COMB_DEPTH);
		end else begin
			comb_eff = comb_len_q[line_q];
		end
		comb_next = COMB_LW'(comb_pos_q[line_q]) + COMB_LW'(1);
		if (ap_len_q[line_q] == '0) begin
			ap_eff = AP_LW'(1);
		end else if (ap_len_q[line_q] > AP_LW'(AP_DEPTH)) begin
			ap_eff = AP_LW'(AP_DEPTH);
		end else begin
			ap_eff = ap_len_q[line_q];
		end
		ap_next = AP_LW'(ap_pos_q[line_q]) + AP_LW'(1);
	end

	// Clamp the final value to the output range
	always_comb begin
		if (acc_q > 21'sd2047) begin
			clamp_out = 12'h7ff;
		end else if (acc_q < -21'sd2048) begin
			clamp_out = 12'h800;
		end else begin
			clamp_out = acc_q[11:0];
		end
	end

	// Memory write controls
	always_comb begin
		comb_we    = (state_q == ST_CLEAR) || (state_q == ST_C_WR);
		comb_waddr = (state_q == ST_CLEAR) ? clr_q : comb_addr;
		comb_wdata = (state_q == ST_CLEAR) ? 16'd0 : comb_sat;
		ap_we      = (state_q == ST_CLEAR) || (state_q == ST_A_WR);
		ap_waddr   = (state_q == ST_CLEAR) ? clr_q[AP_AW-1:0] : ap_addr;
		ap_wdata   = (state_q == ST_CLEAR) ? 16'd0 : ap_sat;
	end

	// Delay memories, registered read
	always_ff @(posedge clk) begin
		if (comb_we) begin
			comb_mem[comb_waddr] <= comb_wdata;
		end
		comb_rd_q <= comb_mem[comb_addr];
	end

	always_ff @(posedge clk) begin
		if (ap_we) begin
			ap_mem[ap_waddr] <= ap_wdata;
		end
		ap_rd_q <= ap_mem[ap_addr];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == COMB_AW'(COMB_MEM_SIZE - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (in_acc) state_d = ST_C_RD;
			ST_C_RD:   state_d = ST_C_MUL;
			ST_C_MUL:  state_d = ST_C_DAMP;
			ST_C_DAMP: state_d = ST_C_WR;
			ST_C_WR:   state_d = (line_q == LINE_IW'(NUM_COMB - 1)) ? ST_A_RD : ST_C_RD;
			ST_A_RD:   state_d = ST_A_WR;
			ST_A_WR:   state_d = (line_q == LINE_IW'(NUM_ALLPASS - 1)) ? ST_DONE : ST_A_RD;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		s_tready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Clear counter, line index, positions and lowpass stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			line_q <= '0;
			for (int i = 0; i < NUM_COMB; i++) begin
				comb_pos_q[i] <= '0;
				lp_q[i]       <= '0;
			end
			for (int i = 0; i < NUM_ALLPASS; i++) begin
				ap_pos_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + COMB_AW'(1);
			end
			if (in_acc) begin
				line_q <= '0;
			end
			if (state_q == ST_C_DAMP) begin
				lp_q[line_q] <= damp_sum[30:15];
			end
			if (state_q == ST_C_WR) begin
				comb_pos_q[line_q] <= (comb_next >= comb_eff) ? '0 : comb_next[COMB_PW-1:0];
				line_q <= line_q + LINE_IW'(1);
			end
			if (state_q == ST_A_WR) begin
				ap_pos_q[line_q] <= (ap_next >= ap_eff) ? '0 : ap_next[AP_PW-1:0];
				line_q <= line_q + LINE_IW'(1);
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_q  <= $signed(s_tdata);
			sum_q <= '0;
		end
		if (state_q == ST_C_MUL) begin
			prod_s2 <= 33'($signed(comb_rd_q)) * 33'(DAMP2_Q15);
			sum_q   <= sum_q + 18'($signed(comb_rd_q));
		end
		if (state_q == ST_C_WR && line_q == LINE_IW'(NUM_COMB - 1)) begin
			acc_q <= 21'(sum_q >>> 2);
		end
		if (state_q == ST_A_WR) begin
			acc_q <= ap_y;
		end
		if (state_q == ST_DONE && out_free) begin
			m_data_q <= clamp_out;
		end
	end

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comb_len_q[0] <= COMB_LEN_A_RST;
			comb_len_q[1] <= COMB_LEN_B_RST;
			comb_len_q[2] <= COMB_LEN_C_RST;
			comb_len_q[3] <= COMB_LEN_D_RST;
			ap_len_q[0]   <= AP_LEN_A_RST;
			ap_len_q[1]   <= AP_LEN_B_RST;
			ap_len_q[2]   <= AP_LEN_C_RST;
			ap_len_q[3]   <= AP_LEN_D_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COMB_A: comb_len_q[0] <= cfg_data;
				REG_COMB_B: comb_len_q[1] <= cfg_data;
				REG_COMB_C: comb_len_q[2] <= cfg_data;
				REG_COMB_D: comb_len_q[3] <= cfg_data;
				REG_AP_A:   ap_len_q[0]   <= cfg_data[AP_LW-1:0];
				REG_AP_B:   ap_len_q[1]   <= cfg_data[AP_LW-1:0];
				REG_AP_C:   ap_len_q[2]   <= cfg_data[AP_LW-1:0];
				REG_AP_D:   ap_len_q[3]   <= cfg_data[AP_LW-1:0];
				default:    ;
			endcase
		end
	end

	// A new sample starts on the first comb line
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_C_RD && line_q == '0))
		else $error("sample did not start at first comb line");

	// A result appears only on leaving the final stage
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_DONE)
		else $error("result loaded outside final stage");

	// No sample is taken while the memories are being cleared
	a_no_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("input ready during clearing pass");

endmodule
